// File: hw/rtl/first_unique_symbol_tracker_core_macros.svh
// Assertion macros for the tracker's port-level checker.
`ifndef FIRST_UNIQUE_SYMBOL_TRACKER_CORE_MACROS_SVH
`define FIRST_UNIQUE_SYMBOL_TRACKER_CORE_MACROS_SVH

// Check on every rising edge of i_clk, skipping edges while reset is held.
`define FUST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every rising edge of i_clk, reset included.
`define FUST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hw/rtl/fust_pkg.sv
// Shared constants of the first unique symbol tracker.
package fust_pkg;

    // width of one stream symbol and of the reported result
    localparam int SYM_W             = 8;
    // default alphabet: every byte value
    localparam int ALPHABET_SIZE_DEF = 256;

endpackage

// File: hw/rtl/first_unique_symbol_tracker_core.sv
// Top level of the first unique symbol tracker: status, list and handshake control.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  input   | in        | i_valid / o_ready  | i_symbol[7:0], i_start_of_stream
//  result  | out       | o_valid / i_ready  | o_found, o_first_unique[7:0]
//
// One item per cycle sustained while i_ready stays high; each result is registered
// as its item leaves the input register. Link and repeat memories are read at
// acceptance, so the list update runs while the item waits in the input register.
// Reset (i_rst_n low, synchronous) empties the list, marks every symbol unseen
// and drops any item in flight; no clearing pass is needed.
// A stalled result holds in the output register; one more item waits in the
// input register, and acceptance stops only when both are full.
module first_unique_symbol_tracker_core #(
    parameter int ALPHABET_SIZE = fust_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [fust_pkg::SYM_W-1:0] i_symbol,
    input  logic                      i_start_of_stream,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_found,
    output logic [fust_pkg::SYM_W-1:0] o_first_unique
);

    localparam int         SW        = fust_pkg::SYM_W;
    localparam int         AW        = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam logic [SW:0] ALPHA_LIM = (SW + 1)'(ALPHABET_SIZE);

    // handshake
    logic acc;
    logic adv;

    // input register
    logic          r_in_vld;
    logic [SW-1:0] r_sym;
    logic          r_sos;

    // tracking state: per-symbol seen flags and the list ends; the repeat
    // flag of a seen symbol lives in its own memory
    logic [ALPHABET_SIZE-1:0] r_seen, n_seen;
    logic [AW-1:0]            r_head, n_head;
    logic [AW-1:0]            r_tail, n_tail;
    logic                     r_empty, n_empty;

    // result register
    logic          r_out_vld;
    logic          r_found, n_found;
    logic [SW-1:0] r_first, n_first;

    // link and repeat memory ports
    logic          in_rng_i;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] rd_next;
    logic [AW-1:0] rd_prev;
    logic          rd_rep;
    logic          wr_next_en, wr_prev_en, wr_rep_en;
    logic [AW-1:0] wr_next_addr, wr_next_data;
    logic [AW-1:0] wr_prev_addr, wr_prev_data;
    logic          wr_rep_data;

    // list update terms
    logic                     inr;
    logic [AW-1:0]            s;
    logic [ALPHABET_SIZE-1:0] e_seen;
    logic                     e_empty;
    logic [AW-1:0]            e_head, e_tail;
    logic                     st_seen, st_once;
    logic                     do_app, do_unl;

    // Advance the held item whenever the result slot is free or being emptied.
    assign adv     = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || adv;
    assign acc     = i_valid && o_ready;

    // Read both links and the repeat flag of the incoming symbol now; data
    // lands with the item.
    assign in_rng_i = {1'b0, i_symbol} < ALPHA_LIM;
    assign rd_addr  = in_rng_i ? i_symbol[AW-1:0] : '0;

    fust_link_ram #(
        .DEPTH  (ALPHABET_SIZE),
        .DATA_W (AW)
    ) u_next_ram (
        .i_clk     (i_clk),
        .i_rd_en   (acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_next),
        .i_wr_en   (wr_next_en),
        .i_wr_addr (wr_next_addr),
        .i_wr_data (wr_next_data)
    );

    fust_link_ram #(
        .DEPTH  (ALPHABET_SIZE),
        .DATA_W (AW)
    ) u_prev_ram (
        .i_clk     (i_clk),
        .i_rd_en   (acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_prev),
        .i_wr_en   (wr_prev_en),
        .i_wr_addr (wr_prev_addr),
        .i_wr_data (wr_prev_data)
    );

    // repeat flag, meaningful only while the symbol's seen flag is set
    fust_link_ram #(
        .DEPTH  (ALPHABET_SIZE),
        .DATA_W (1)
    ) u_rep_ram (
        .i_clk     (i_clk),
        .i_rd_en   (acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_rep),
        .i_wr_en   (wr_rep_en),
        .i_wr_addr (s),
        .i_wr_data (wr_rep_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (acc) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_sym <= i_symbol;
            r_sos <= i_start_of_stream;
        end
    end

    // List update for the held item. A start flag wipes the state first, so the
    // symbol, if in range, then takes the append path and no stale link is read.
    always_comb begin
        inr     = {1'b0, r_sym} < ALPHA_LIM;
        s       = inr ? r_sym[AW-1:0] : '0;
        e_seen  = r_sos ? '0 : r_seen;
        e_empty = r_sos | r_empty;
        e_head  = r_sos ? '0 : r_head;
        e_tail  = r_sos ? '0 : r_tail;
        st_seen = inr && e_seen[s];
        st_once = st_seen && !rd_rep;
        do_app  = inr && !st_seen;
        do_unl  = st_once;

        n_seen       = e_seen;
        n_empty      = e_empty;
        n_head       = e_head;
        n_tail       = e_tail;
        wr_next_en   = 1'b0;
        wr_next_addr = e_tail;
        wr_next_data = s;
        wr_prev_en   = 1'b0;
        wr_prev_addr = s;
        wr_prev_data = e_tail;
        wr_rep_en    = 1'b0;
        wr_rep_data  = 1'b0;

        if (do_app) begin
            // first sighting: append at the tail, clear the repeat flag
            n_seen[s]   = 1'b1;
            wr_rep_en   = adv;
            wr_rep_data = 1'b0;
            if (e_empty) begin
                n_head  = s;
                n_tail  = s;
                n_empty = 1'b0;
            end else begin
                wr_next_en = adv;
                wr_prev_en = adv;
                n_tail     = s;
            end
        end else if (do_unl) begin
            // second sighting: drop from the list, mark repeated
            wr_rep_en   = adv;
            wr_rep_data = 1'b1;
            if (!e_empty) begin
                if ((e_head == s) && (e_tail == s)) begin
                    n_empty = 1'b1;
                    n_head  = '0;
                    n_tail  = '0;
                end else if (e_head == s) begin
                    n_head = rd_next;
                end else if (e_tail == s) begin
                    n_tail = rd_prev;
                end else begin
                    // splice neighbors around the middle member
                    wr_next_en   = adv;
                    wr_next_addr = rd_prev;
                    wr_next_data = rd_next;
                    wr_prev_en   = adv;
                    wr_prev_addr = rd_next;
                    wr_prev_data = rd_prev;
                end
            end
        end

        n_found = !n_empty;
        n_first = n_empty ? '0 : SW'(n_head);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else if (adv) begin
            r_seen  <= n_seen;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

    // Hold the result until taken; refill in the same cycle it leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_found <= n_found;
            r_first <= n_first;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_found        = r_found;
    assign o_first_unique = r_first;

endmodule

// File: hw/rtl/fust_link_ram.sv
// Link memory: one write port, one registered read port with write-through.
module fust_link_ram #(
    parameter int DEPTH  = fust_pkg::ALPHABET_SIZE_DEF,
    parameter int DATA_W = fust_pkg::SYM_W
) (
    input  logic                                    i_clk,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]                       o_rd_data,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]                       i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // a write landing on the address being read wins over the stored word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/fust_checker.sv
// Port-level checker for the first unique symbol tracker, bound to the top level.
`include "first_unique_symbol_tracker_core_macros.svh"

module fust_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic                       o_found,
    input logic [fust_pkg::SYM_W-1:0] o_first_unique
);

    // no result survives reset
    `FUST_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !o_valid, "result valid after reset")

    // a stalled result holds its payload
    `FUST_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_found) && $stable(o_first_unique), "stalled result changed")

    // no unique symbol means a zero symbol field
    `FUST_ASSERT(a_none_is_zero, o_valid && !o_found |-> o_first_unique == '0, "symbol set without found")

    // with the result slot empty the input side never stalls
    `FUST_ASSERT(a_no_idle_stall, !o_valid |-> o_ready, "input stalled while result slot empty")

endmodule

bind first_unique_symbol_tracker_core fust_checker u_fust_checker (.*);

// File: tb/sv/first_unique_symbol_tracker_core_chk.sv
// Checker for the first unique symbol tracker: predicts each result and compares it.
module first_unique_symbol_tracker_core_chk #(
    parameter int ALPHABET_SIZE = fust_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [fust_pkg::SYM_W-1:0] i_symbol,
    input  logic                       i_start_of_stream,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_found,
    input  logic [fust_pkg::SYM_W-1:0] i_first_unique,
    output int                         o_err_count,
    output int                         o_pending
);

    typedef enum logic [1:0] {
        SYM_UNSEEN   = 2'd0,
        SYM_ONCE     = 2'd1,
        SYM_REPEATED = 2'd2
    } sym_state_e;

    typedef logic [fust_pkg::SYM_W-1:0] sym_t;

    typedef struct packed {
        logic found;
        sym_t first_unique;
    } head_report_t;

    sym_state_e   sym_state [256];
    sym_t         succ_sym  [256];
    sym_t         pred_sym  [256];
    sym_t         oldest_sym;
    sym_t         newest_sym;
    logic         no_singles;
    head_report_t head_reports_q [$];

    function automatic void forget_stream();
        foreach (sym_state[k]) sym_state[k] = SYM_UNSEEN;
        oldest_sym = '0;
        newest_sym = '0;
        no_singles = 1'b1;
    endfunction

    // Apply one symbol to the list of singles and report the oldest single.
    function automatic head_report_t track_symbol(sym_t sym, logic sos);
        head_report_t rep;
        sym_t         p;
        sym_t         n;
        if (sos) forget_stream();
        if (int'(sym) < ALPHABET_SIZE) begin
            case (sym_state[sym])
                SYM_UNSEEN: begin
                    if (no_singles) begin
                        oldest_sym = sym;
                        newest_sym = sym;
                        no_singles = 1'b0;
                    end else begin
                        succ_sym[newest_sym] = sym;
                        pred_sym[sym]        = newest_sym;
                        newest_sym           = sym;
                    end
                    sym_state[sym] = SYM_ONCE;
                end
                SYM_ONCE: begin
                    if (!no_singles) begin
                        if (oldest_sym == sym && newest_sym == sym) begin
                            no_singles = 1'b1;
                            oldest_sym = '0;
                            newest_sym = '0;
                        end else if (oldest_sym == sym) begin
                            oldest_sym = succ_sym[sym];
                        end else if (newest_sym == sym) begin
                            newest_sym = pred_sym[sym];
                        end else begin
                            p = pred_sym[sym];
                            n = succ_sym[sym];
                            succ_sym[p] = n;
                            pred_sym[n] = p;
                        end
                    end
                    sym_state[sym] = SYM_REPEATED;
                end
                default: ;
            endcase
        end
        rep.found        = !no_singles;
        rep.first_unique = no_singles ? sym_t'(0) : oldest_sym;
        return rep;
    endfunction

    always @(posedge i_clk) begin
        head_report_t exp_rep;
        int           errs;
        errs = 0;
        if (!i_rst_n) begin
            forget_stream();
            head_reports_q.delete();
            o_err_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                head_reports_q.push_back(track_symbol(i_symbol, i_start_of_stream));
            if (i_out_valid && i_out_ready) begin
                if (head_reports_q.size() == 0) begin
                    $display("%0t: unexpected result found=%0b first_unique=%0d",
                             $time, i_found, i_first_unique);
                    errs++;
                end else begin
                    exp_rep = head_reports_q.pop_front();
                    if (i_found !== exp_rep.found) begin
                        $display("%0t: found expected %0b actual %0b",
                                 $time, exp_rep.found, i_found);
                        errs++;
                    end
                    if (i_first_unique !== exp_rep.first_unique) begin
                        $display("%0t: first_unique expected %0d actual %0d",
                                 $time, exp_rep.first_unique, i_first_unique);
                        errs++;
                    end
                end
            end
            o_err_count <= o_err_count + errs;
        end
        o_pending <= head_reports_q.size();
    end

endmodule

// File: tb/sv/first_unique_symbol_tracker_core_tb.sv
// Testbench top for the first unique symbol tracker: stimulus, backpressure and verdict.
module first_unique_symbol_tracker_core_tb;

    localparam int N_RANDOM_ITEMS = 1150;
    // cycles with no handshake on either side before the run is declared hung
    localparam int HANG_LIMIT     = 4000;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [7:0] symbol     = '0;
    logic       sos        = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic       found;
    logic [7:0] first_unique;

    int         err_count;
    int         pending;
    int         sent_count = 0;
    bit         calm       = 1'b0;
    int         ready_hold = 0;
    int         ready_roll;
    int         idle_cycles = 0;

    always #5 clk = ~clk;

    first_unique_symbol_tracker_core u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (in_valid),
        .o_ready           (in_ready),
        .i_symbol          (symbol),
        .i_start_of_stream (sos),
        .o_valid           (out_valid),
        .i_ready           (out_ready),
        .o_found           (found),
        .o_first_unique    (first_unique)
    );

    first_unique_symbol_tracker_core_chk u_chk (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_symbol          (symbol),
        .i_start_of_stream (sos),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_found           (found),
        .i_first_unique    (first_unique),
        .o_err_count       (err_count),
        .o_pending         (pending)
    );

    // Result side: hold ready high or low for random runs, mostly short,
    // now and then a long stall. Keep it high throughout calm stretches.
    always @(negedge clk) begin
        if (calm) begin
            out_ready  <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 60) begin
                out_ready  <= 1'b1;
                ready_hold <= $urandom_range(0, 6);
            end else if (ready_roll < 92) begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end else begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(8, 40);
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= HANG_LIMIT) begin
                $display("first_unique_symbol_tracker_core_tb: errors");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Pick the idle gap before the next item: mostly none or short.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Offer one item and hold it until accepted. Entered and left at a falling edge,
    // so valid stays high between back-to-back items without a glitch.
    task automatic offer_symbol(input logic [7:0] sym, input logic clear);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        symbol   = sym;
        sos      = clear;
        do @(posedge clk); while (!(in_valid && in_ready));
        sent_count++;
        @(negedge clk);
    endtask

    initial begin
        int          run_len;
        int          span;
        logic [7:0]  base;
        int          roll;
        logic [7:0]  sym;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: append, unlink head, middle and tail, third sighting,
        // empty list, repeated symbol on an empty list, start flag on a
        // previously seen symbol, and bytes that flip every bit.
        offer_symbol(8'd0,   1'b1);
        offer_symbol(8'd255, 1'b0);
        offer_symbol(8'd0,   1'b0);
        offer_symbol(8'd0,   1'b0);
        offer_symbol(8'd128, 1'b0);
        offer_symbol(8'd1,   1'b0);
        offer_symbol(8'd128, 1'b0);
        offer_symbol(8'd1,   1'b0);
        offer_symbol(8'd255, 1'b0);
        offer_symbol(8'd255, 1'b0);
        offer_symbol(8'd85,  1'b0);
        offer_symbol(8'd170, 1'b0);
        offer_symbol(8'd85,  1'b1);
        offer_symbol(8'd85,  1'b1);
        offer_symbol(8'd85,  1'b0);
        offer_symbol(8'd7,   1'b0);
        offer_symbol(8'd170, 1'b0);
        offer_symbol(8'd99,  1'b0);
        offer_symbol(8'd7,   1'b0);
        offer_symbol(8'd0,   1'b0);
        offer_symbol(8'd255, 1'b1);
        offer_symbol(8'd255, 1'b0);
        offer_symbol(8'd255, 1'b0);

        // Random part: mostly streams that open with the start flag and draw
        // from a narrow window of symbols so repeats are common; a few run on
        // without the flag or take a stray start flag mid-stream.
        sent_count = 0;
        while (sent_count < N_RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 99) < 20);
            roll = $urandom_range(0, 99);
            case ($urandom_range(0, 5))
                0: span = 2;
                1: span = 4;
                2: span = 8;
                3: span = 16;
                4: span = 64;
                default: span = 256;
            endcase
            base    = 8'($urandom_range(0, 255));
            run_len = (roll < 90) ? $urandom_range(3, 40) : $urandom_range(100, 320);
            for (int k = 0; k < run_len && sent_count < N_RANDOM_ITEMS; k++) begin
                sym = 8'(int'(base) + $urandom_range(0, span - 1));
                if (k == 0)
                    offer_symbol(sym, $urandom_range(0, 99) < 90);
                else
                    offer_symbol(sym, $urandom_range(0, 99) < 2);
            end
        end

        // Drain: drop valid, let every result out, then allow the pipeline to settle.
        in_valid = 1'b0;
        calm     = 1'b1;
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);

        if (err_count == 0 && pending == 0)
            $display("first_unique_symbol_tracker_core_tb: clean");
        else
            $display("first_unique_symbol_tracker_core_tb: errors");
        $finish;
    end

endmodule
